@@ hdl/wlg_pkg.sv @@
// ----------------------------------------------------------------------------
// wlg_pkg
// Shared types and constants of the window/level gray mapping block.
// ----------------------------------------------------------------------------
package wlg_pkg;

  // Fraction bits of the fixed point slope, intercept, center and width.
  localparam int FRAC_BITS = 16;

  // Queue between the front and the back part.
  localparam int QDEPTH = 8;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Width of 2*v*2^F - 2*center + width, and of that sum times 255.
  localparam int SUM_W = (((17 + FRAC_BITS) > 33) ? (17 + FRAC_BITS) : 33) + 2;
  localparam int NUM_W = SUM_W + 8;

  // Item commands.
  localparam logic CMD_MEASURE = 1'b0;
  localparam logic CMD_MAP     = 1'b1;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_HIGH_BIT     = 3'd0,
    REG_SIGNED       = 3'd1,
    REG_SLOPE        = 3'd2,
    REG_INTERCEPT    = 3'd3,
    REG_CENTER       = 3'd4,
    REG_WIDTH        = 3'd5
  } reg_idx_e;

  // Configuration seen by both parts.
  typedef struct packed {
    logic [3:0]  high_bit;
    logic        signed_samples;
    logic [31:0] slope;
    logic [31:0] intercept;
    logic [31:0] center;
    logic [31:0] width;
  } cfg_t;

  // One rescaled item waiting in the queue.
  typedef struct packed {
    logic        cmd;
    logic        frame_start;
    logic [15:0] value;
  } qitem_t;

endpackage

@@ hdl/wlg_front.sv @@
// ----------------------------------------------------------------------------
// wlg_front
// Clips each sample to its stored bits and applies the rescale, in three
// pipeline stages: clip, multiply, add intercept with truncate and saturate.
// ----------------------------------------------------------------------------
module wlg_front import wlg_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cfg_t         cfg_i,
  input  logic         in_valid_i,
  input  logic         cmd_i,
  input  logic [15:0]  sample_i,
  input  logic         frame_start_i,
  output logic [1:0]   inflight_o,
  output logic         push_o,
  output qitem_t       item_o
);

  logic               v1_q, v2_q, v3_q;
  logic               cmd1_q, cmd2_q, cmd3_q;
  logic               fs1_q, fs2_q, fs3_q;
  logic signed [16:0] clip_d, clip_q;
  logic signed [48:0] prod_q;
  logic [15:0]        val3_d, val3_q;
  logic [15:0]        mask;
  logic signed [49:0] sum;
  logic signed [49:0] quo;

  // Clip the sample: mask the bits above high_bit or sign-extend from it.
  always_comb begin
    mask = 16'hffff >> (4'd15 - cfg_i.high_bit);
    if (cfg_i.signed_samples && sample_i[cfg_i.high_bit]) begin
      clip_d = {1'b1, sample_i | ~mask};
    end else begin
      clip_d = {1'b0, sample_i & mask};
    end
  end

  // Add the intercept, truncate toward zero and saturate to 16 bits.
  always_comb begin
    sum = {prod_q[48], prod_q} + {{18{cfg_i.intercept[31]}}, cfg_i.intercept};
    quo = sum >>> FRAC_BITS;
    if (sum[49] && (|sum[FRAC_BITS-1:0])) begin
      quo = quo + 50'sd1;
    end
    if (quo > 50'sd32767) begin
      val3_d = 16'h7fff;
    end else if (quo < -50'sd32768) begin
      val3_d = 16'h8000;
    end else begin
      val3_d = quo[15:0];
    end
  end

  // Valid bits of the stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    clip_q <= clip_d;
    cmd1_q <= cmd_i;
    fs1_q  <= frame_start_i;
    prod_q <= clip_q * $signed(cfg_i.slope);
    cmd2_q <= cmd1_q;
    fs2_q  <= fs1_q;
    val3_q <= val3_d;
    cmd3_q <= cmd2_q;
    fs3_q  <= fs2_q;
  end

  assign inflight_o = 2'({1'b0, v1_q} + {1'b0, v2_q} + {1'b0, v3_q});
  assign push_o     = v3_q;
  assign item_o     = '{cmd: cmd3_q, frame_start: fs3_q, value: val3_q};

endmodule

@@ hdl/wlg_fifo.sv @@
// ----------------------------------------------------------------------------
// wlg_fifo
// Short queue of rescaled items between the front and the back part.
// ----------------------------------------------------------------------------
module wlg_fifo import wlg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  qitem_t            item_i,
  input  logic              pop_i,
  output logic              empty_o,
  output logic [QCNT_W-1:0] count_o,
  output qitem_t            item_o
);

  qitem_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wptr_q, rptr_q;
  logic [QCNT_W-1:0]   cnt_q;

  // Storage write.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= item_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign item_o  = mem_q[rptr_q];

endmodule

@@ hdl/wlg_back.sv @@
// ----------------------------------------------------------------------------
// wlg_back
// Updates the frame range on measure requests and maps map requests to gray by
// threshold, offset or window/range ratio, divided one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wlg_back import wlg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        empty_i,
  input  qitem_t      item_i,
  output logic        pop_o,
  input  logic        out_pop_i,
  output logic        out_valid_o,
  output logic [7:0]  gray_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCALE = 6'b000010,
    S_NORM  = 6'b000100,
    S_CHK   = 6'b001000,
    S_DIV   = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;

  state_e                   state_q, state_d;
  logic signed [NUM_W-1:0]  num_q, num_d, den_q, den_d, rem_q, rem_d, dsh_q, dsh_d;
  logic [7:0]               quo_q, quo_d, res_q, res_d;
  logic [2:0]               cnt_q, cnt_d;
  logic [15:0]              lo_q, lo_d, hi_q, hi_d;
  logic                     ov_q, ov_d;
  logic [7:0]               gray_q, gray_d;

  logic signed [15:0]       v;
  logic signed [SUM_W-1:0]  vq, c_ext, w_ext;
  logic signed [16:0]       d;
  logic                     win_mode, ge;

  always_comb begin
    v        = item_i.value;
    vq       = {{(SUM_W-16){v[15]}}, v} <<< FRAC_BITS;
    c_ext    = {{(SUM_W-32){cfg_i.center[31]}}, cfg_i.center};
    w_ext    = {{(SUM_W-32){cfg_i.width[31]}}, cfg_i.width};
    d        = {v[15], v} - {lo_q[15], lo_q};
    win_mode = (cfg_i.center != '0) || (cfg_i.width != '0);
    ge       = (rem_q >= dsh_q);
  end

  // Sequencer: take a request, update the range or form and divide the ratio.
  always_comb begin
    state_d = state_q;
    num_d   = num_q;
    den_d   = den_q;
    rem_d   = rem_q;
    dsh_d   = dsh_q;
    quo_d   = quo_q;
    res_d   = res_q;
    cnt_d   = cnt_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    ov_d    = ov_q && !out_pop_i;
    gray_d  = gray_q;
    pop_o   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          if (item_i.cmd == CMD_MEASURE) begin
            if (item_i.frame_start) begin
              lo_d = item_i.value;
              hi_d = item_i.value;
            end else begin
              if (v < $signed(lo_q)) lo_d = item_i.value;
              if (v > $signed(hi_q)) hi_d = item_i.value;
            end
          end else if (win_mode) begin
            if (cfg_i.width == '0) begin
              res_d   = (vq < c_ext) ? 8'd0 : 8'd255;
              state_d = S_OUT;
            end else begin
              num_d   = NUM_W'((vq <<< 1) - (c_ext <<< 1) + w_ext);
              den_d   = NUM_W'(w_ext) <<< 1;
              state_d = S_SCALE;
            end
          end else if ($signed(hi_q) > $signed(lo_q)) begin
            num_d   = NUM_W'(d);
            den_d   = NUM_W'($signed({hi_q[15], hi_q}) - $signed({lo_q[15], lo_q}));
            state_d = S_SCALE;
          end else begin
            if (d <= 17'sd0) res_d = 8'd0;
            else if (d > 17'sd255) res_d = 8'd255;
            else res_d = d[7:0];
            state_d = S_OUT;
          end
        end
      end
      S_SCALE: begin
        num_d   = (num_q <<< 8) - num_q;
        state_d = S_NORM;
      end
      S_NORM: begin
        if (den_q < 0) begin
          num_d = -num_q;
          den_d = -den_q;
        end
        state_d = S_CHK;
      end
      S_CHK: begin
        if (num_q <= 0) begin
          res_d   = 8'd0;
          state_d = S_OUT;
        end else if (num_q >= (den_q <<< 8)) begin
          res_d   = 8'd255;
          state_d = S_OUT;
        end else begin
          rem_d   = num_q;
          dsh_d   = den_q <<< 7;
          cnt_d   = 3'd7;
          quo_d   = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (ge) rem_d = rem_q - dsh_q;
        dsh_d = dsh_q >>> 1;
        quo_d = {quo_q[6:0], ge};
        cnt_d = cnt_q - 3'd1;
        if (cnt_q == 3'd0) begin
          res_d   = {quo_q[6:0], ge};
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!ov_q || out_pop_i) begin
          ov_d    = 1'b1;
          gray_d  = res_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control and range state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
      lo_q    <= '0;
      hi_q    <= '0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quo_q  <= quo_d;
    res_q  <= res_d;
    cnt_q  <= cnt_d;
    gray_q <= gray_d;
  end

  assign out_valid_o = ov_q;
  assign gray_o      = gray_q;

  // The partial remainder stays below twice the shifted divisor.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> rem_q < (dsh_q <<< 1))
    else $error("remainder out of bound");

  // The divisor is positive once normalized.
  a_den_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHK || state_q == S_DIV) |-> den_q > 0)
    else $error("divisor not positive");

  // The frame range never inverts.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $signed(lo_q) <= $signed(hi_q))
    else $error("range low above range high");

endmodule

@@ hdl/window_level_to_8bit_core.sv @@
// ----------------------------------------------------------------------------
// window_level_to_8bit_core
// Maps 16-bit image samples to 8-bit gray by rescale and window or range.
// ----------------------------------------------------------------------------
// Path: a request passes the front stages and the queue. A measure then
// updates the range in the back idle state; a map goes straight to output in
// flat or zero-width cases, else via scale, normalize, check and the 8-step
// divider unless the ratio saturates. Throughput: one request per cycle into
// the front pipeline while not full; the back takes requests only from idle.
// Reset: asynchronous, clears range, queue, output and registers to defaults.
module window_level_to_8bit_core import wlg_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  input  logic         push,
  output logic         full,
  input  logic         command_i,
  input  logic [15:0]  sample_i,
  input  logic         frame_start_i,
  output logic         empty,
  input  logic         pop,
  output logic [7:0]   gray_o
);

  cfg_t              cfg_q;
  reg_idx_e          idx;
  logic [1:0]        inflight;
  logic              fe_push, fifo_empty, be_pop, out_valid, accept;
  qitem_t            fe_item, fifo_item;
  logic [QCNT_W-1:0] fifo_cnt;

  assign idx    = reg_idx_e'(paddr[4:2]);
  assign pready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.high_bit       <= 4'd15;
      cfg_q.signed_samples <= 1'b0;
      cfg_q.slope          <= 32'(1) << FRAC_BITS;
      cfg_q.intercept      <= '0;
      cfg_q.center         <= '0;
      cfg_q.width          <= '0;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_HIGH_BIT:  cfg_q.high_bit       <= pwdata[3:0];
        REG_SIGNED:    cfg_q.signed_samples <= pwdata[0];
        REG_SLOPE:     cfg_q.slope          <= pwdata;
        REG_INTERCEPT: cfg_q.intercept      <= pwdata;
        REG_CENTER:    cfg_q.center         <= pwdata;
        REG_WIDTH:     cfg_q.width          <= pwdata;
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    unique case (idx)
      REG_HIGH_BIT:  prdata = {28'd0, cfg_q.high_bit};
      REG_SIGNED:    prdata = {31'd0, cfg_q.signed_samples};
      REG_SLOPE:     prdata = cfg_q.slope;
      REG_INTERCEPT: prdata = cfg_q.intercept;
      REG_CENTER:    prdata = cfg_q.center;
      REG_WIDTH:     prdata = cfg_q.width;
      default:       prdata = '0;
    endcase
  end

  // Full counts queue entries plus requests still in the front pipeline.
  assign full   = ((QCNT_W+1)'(fifo_cnt) + (QCNT_W+1)'(inflight)) >= (QCNT_W+1)'(QDEPTH);
  assign accept = push && !full;

  wlg_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (accept),
    .cmd_i         (command_i),
    .sample_i      (sample_i),
    .frame_start_i (frame_start_i),
    .inflight_o    (inflight),
    .push_o        (fe_push),
    .item_o        (fe_item)
  );

  wlg_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fe_push),
    .item_i  (fe_item),
    .pop_i   (be_pop),
    .empty_o (fifo_empty),
    .count_o (fifo_cnt),
    .item_o  (fifo_item)
  );

  wlg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (fifo_empty),
    .item_i      (fifo_item),
    .pop_o       (be_pop),
    .out_pop_i   (pop),
    .out_valid_o (out_valid),
    .gray_o      (gray_o)
  );

  assign empty = !out_valid;

endmodule

@@ tb/sv/tb_window_level_to_8bit_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_window_level_to_8bit_core
// Self-checking bench for the window/level gray mapping core. A directed table
// and then constrained-by-hand random traffic are pushed through the request
// queue; every popped gray level is compared with a local gray predictor.
// ----------------------------------------------------------------------------
module tb_window_level_to_8bit_core;
  import wlg_pkg::*;

  localparam int LIMIT = 20000;
  localparam int DRAIN_CYCLES = 40;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        push = 1'b0;
  logic        full;
  logic        command_i = 1'b0;
  logic [15:0] sample_i = '0;
  logic        frame_start_i = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  gray_o;

  window_level_to_8bit_core dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predictor state: registers and the measured range.
  logic [3:0]  m_high_bit;
  logic        m_signed;
  logic [31:0] m_slope, m_intercept, m_center, m_width;
  logic signed [15:0] m_lo, m_hi;

  logic [7:0] gray_q[$];
  int errors = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int hold_off = 0;
  bit timed_out = 0;
  int idle_cycles = 0;

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic longint clip_value(input logic [15:0] raw);
    longint span, bits;
    span = longint'(1) << (m_high_bit + 1);
    bits = longint'(raw) & (span - 1);
    if (m_signed && bits[m_high_bit]) return bits - span;
    return bits;
  endfunction

  function automatic longint rescale_value(input longint v);
    longint s, q;
    s = v * longint'($signed(m_slope)) + longint'($signed(m_intercept));
    if (s < 0) q = -((-s) >>> FRAC_BITS);
    else q = s >>> FRAC_BITS;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q;
  endfunction

  function automatic logic [7:0] ratio_gray(input longint num, input longint den);
    longint q;
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    if (num <= 0) return 8'd0;
    q = num / den;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  // Applies one accepted request; returns 1 with the gray level for a map.
  function automatic bit predict_gray(input logic cmd, input logic [15:0] raw,
                                      input logic fs, output logic [7:0] g);
    longint v, c, w, vq, d;
    v = rescale_value(clip_value(raw));
    g = 8'd0;
    if (cmd == CMD_MEASURE) begin
      if (fs) begin
        m_lo = v[15:0];
        m_hi = v[15:0];
      end else begin
        if (v < m_lo) m_lo = v[15:0];
        if (v > m_hi) m_hi = v[15:0];
      end
      return 0;
    end
    if (m_center != 0 || m_width != 0) begin
      c = $signed(m_center);
      w = $signed(m_width);
      vq = v * (longint'(1) << FRAC_BITS);
      if (w == 0) g = (vq < c) ? 8'd0 : 8'd255;
      else g = ratio_gray((2 * vq - 2 * c + w) * 255, 2 * w);
    end else begin
      d = v - longint'(m_lo);
      if (m_hi > m_lo) g = ratio_gray(d * 255, longint'(m_hi) - longint'(m_lo));
      else if (d <= 0) g = 8'd0;
      else g = (d > 255) ? 8'd255 : d[7:0];
    end
    return 1;
  endfunction

  // Register write over the configuration port, mirrored in the predictor.
  task automatic write_reg(input reg_idx_e idx, input logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 5'(4 * idx);
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_HIGH_BIT:  m_high_bit = val[3:0];
      REG_SIGNED:    m_signed = val[0];
      REG_SLOPE:     m_slope = val;
      REG_INTERCEPT: m_intercept = val;
      REG_CENTER:    m_center = val;
      default:       m_width = val;
    endcase
  endtask

  // Push one request; wait until accepted. The valid stays high across items unless a random send gap drops it.
  task automatic send_request(input logic cmd, input logic [15:0] raw, input logic fs,
                              input bit has_want, input logic [7:0] want);
    logic [7:0] g;
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    command_i <= cmd;
    sample_i <= raw;
    frame_start_i <= fs;
    do @(posedge clk_i); while (full);
    if (predict_gray(cmd, raw, fs, g)) begin
      if (has_want && g !== want) report_mismatch("predictor vs table", g, want);
      gray_q.push_back(g);
    end
  endtask

  // Drop the request line right away so the last item is not offered again.
  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk_i);
    while (gray_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Receiver: random stalls plus an optional long hold-off.
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      pop <= 1'b0;
    end else begin
      pop <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);
    end
  end

  // Result checker and stall watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        if (gray_q.size() == 0) begin
          report_mismatch("unexpected gray", gray_o, 8'd0);
        end else begin
          logic [7:0] w;
          w = gray_q.pop_front();
          if (gray_o !== w) report_mismatch("gray", gray_o, w);
        end
      end
      if ((push && !full) || (pop && !empty) || psel)
        idle_cycles <= 0;
      else if (idle_cycles >= LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end else idle_cycles <= idle_cycles + 1;
    end
  end

  typedef struct {
    logic cmd;
    logic [15:0] raw;
    logic fs;
    bit has_want;
    logic [7:0] want;
  } stim_t;

  // Directed table under the reset setting (auto range, identity rescale).
  stim_t directed[] = '{
    '{CMD_MAP,     16'h0000, 1'b0, 1, 8'd0},   // map before any measure
    '{CMD_MAP,     16'h0005, 1'b0, 1, 8'd5},   // flat reset range
    '{CMD_MAP,     16'hffff, 1'b1, 1, 8'd255}, // saturates to 32767, frame start ignored
    '{CMD_MEASURE, 16'h0010, 1'b1, 0, 8'd0},
    '{CMD_MEASURE, 16'h0110, 1'b0, 0, 8'd0},
    '{CMD_MAP,     16'h0010, 1'b0, 1, 8'd0},
    '{CMD_MAP,     16'h0110, 1'b0, 1, 8'd255},
    '{CMD_MAP,     16'h0090, 1'b0, 0, 8'd0},
    '{CMD_MEASURE, 16'h8000, 1'b0, 0, 8'd0},
    '{CMD_MAP,     16'h7fff, 1'b0, 0, 8'd0},
    '{CMD_MAP,     16'h4000, 1'b0, 0, 8'd0},
    '{CMD_MEASURE, 16'h0042, 1'b1, 0, 8'd0},   // flat range
    '{CMD_MAP,     16'h0100, 1'b0, 0, 8'd0},
    '{CMD_MAP,     16'h0040, 1'b0, 1, 8'd0}
  };

  task automatic random_config();
    write_reg(REG_HIGH_BIT, ($urandom_range(1)) ? 32'd15 : $urandom_range(15));
    write_reg(REG_SIGNED, $urandom);
    case ($urandom_range(3))
      0: write_reg(REG_SLOPE, 32'h0001_0000);
      1: write_reg(REG_SLOPE, $urandom);
      2: write_reg(REG_SLOPE, $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000);
      default: write_reg(REG_SLOPE, 32'($signed(($urandom_range(8191)) - 4096)) << 6);
    endcase
    write_reg(REG_INTERCEPT, $urandom_range(1) ? 32'd0 : $urandom);
    case ($urandom_range(3))
      0: begin
        write_reg(REG_CENTER, 32'd0);
        write_reg(REG_WIDTH, 32'd0);
      end
      1: begin
        write_reg(REG_CENTER, $urandom);
        write_reg(REG_WIDTH, 32'd0);
      end
      2: begin
        write_reg(REG_CENTER, $urandom);
        write_reg(REG_WIDTH, $urandom);
      end
      default: begin
        write_reg(REG_CENTER, 32'($signed($urandom_range(2000)) - 1000) << 16);
        write_reg(REG_WIDTH, 32'($signed($urandom_range(1000)) - 300) << 16);
      end
    endcase
  endtask

  // Stimulus: directed table, extreme settings, then random phases.
  initial begin
    m_high_bit = 4'd15;
    m_signed = 1'b0;
    m_slope = 32'h0001_0000;
    m_intercept = '0;
    m_center = '0;
    m_width = '0;
    m_lo = '0;
    m_hi = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i])
      send_request(directed[i].cmd, directed[i].raw, directed[i].fs,
                   directed[i].has_want, directed[i].want);
    wait_idle();

    // Signed narrow samples, negative slope, zero-width window.
    write_reg(REG_HIGH_BIT, 32'd7);
    write_reg(REG_SIGNED, 32'd1);
    write_reg(REG_SLOPE, 32'hfffe_0000);
    write_reg(REG_INTERCEPT, 32'h8000_0000);
    write_reg(REG_CENTER, 32'h0000_0001);
    write_reg(REG_WIDTH, 32'd0);
    send_request(CMD_MAP, 16'hff80, 1'b0, 0, 8'd0);
    send_request(CMD_MAP, 16'h007f, 1'b0, 0, 8'd0);
    send_request(CMD_MEASURE, 16'h0001, 1'b1, 0, 8'd0);
    wait_idle();
    write_reg(REG_WIDTH, 32'h8000_0000);
    wait_idle();
    send_request(CMD_MAP, 16'h0080, 1'b0, 0, 8'd0);
    send_request(CMD_MAP, 16'h0000, 1'b0, 0, 8'd0);
    wait_idle();
    write_reg(REG_HIGH_BIT, 32'd0);
    write_reg(REG_WIDTH, 32'h7fff_ffff);
    write_reg(REG_SLOPE, 32'h7fff_ffff);
    wait_idle();
    send_request(CMD_MAP, 16'h0001, 1'b0, 0, 8'd0);
    send_request(CMD_MAP, 16'hfffe, 1'b0, 0, 8'd0);
    wait_idle();

    for (int phase = 0; phase < 9; phase++) begin
      random_config();
      case (phase % 4)
        0: begin send_idle = 0;  recv_idle = 0;  end
        1: begin send_idle = 47; recv_idle = 0;  end
        2: begin send_idle = 0;  recv_idle = 47; end
        default: begin send_idle = 13; recv_idle = 13; end
      endcase
      if (phase == 2) hold_off = 200;
      // A measured frame, then mapping with random content and some noise.
      for (int k = 0; k < 50; k++) begin
        logic cmd;
        logic [15:0] raw;
        cmd = (k < 12) ? CMD_MEASURE : CMD_MAP;
        if ($urandom_range(9) == 0) cmd = 1'($urandom);
        raw = $urandom_range(3) == 0 ? ($urandom_range(1) ? 16'hffff : 16'h0000)
                                     : 16'($urandom);
        send_request(cmd, raw, (k == 0) ? 1'b1 : ($urandom_range(15) == 0), 0, 8'd0);
      end
      wait_idle();
    end

    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

@@ files.f @@
hdl/wlg_pkg.sv
hdl/wlg_front.sv
hdl/wlg_fifo.sv
hdl/wlg_back.sv
hdl/window_level_to_8bit_core.sv
tb/sv/tb_window_level_to_8bit_core.sv
